>>> design/bpc_pkg.sv
// Shared widths, register indexes and pipeline control type for the
// barometric compensation core. No dependencies.
package bpc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int IDX_W   = 3;
    localparam int DT_W    = RAW_W + 1;
    localparam int PROD_W  = DT_W + COEF_W + 1;
    localparam int T1_W    = 18;
    localparam int TC_W    = T1_W + 1;
    localparam int SQ_W    = 2 * TC_W;
    localparam int OFF_W   = 41;
    localparam int SENS_W  = 41;
    localparam int TEMP_W  = 19;
    localparam int P_W     = 32;

    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int TEMP_SHIFT = 23;
    localparam int C2_SHIFT   = 16;
    localparam int C1_SHIFT   = 15;
    localparam int C5_SHIFT   = 8;
    localparam int MUL_SHIFT  = 21;
    localparam int P_SHIFT    = 15;

    // Split of the sensitivity for the final multiplication.
    localparam int SLO_W   = 17;
    localparam int SHI_W   = SENS_W - SLO_W;
    localparam int PLO_W   = RAW_W + SLO_W;
    localparam int PHI_W   = RAW_W + 1 + SHI_W;
    localparam int PROD2_W = PHI_W + SLO_W;
    localparam int Q_W     = PROD2_W - MUL_SHIFT;
    localparam int X_W     = Q_W + 1;

    localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);
    // Distance from the reference temperature to the cold threshold.
    localparam logic signed [TC_W-1:0]   COLD_OFS = TC_W'(3500);

    localparam logic [IDX_W-1:0] IDX_C1 = 3'd0;
    localparam logic [IDX_W-1:0] IDX_C2 = 3'd1;
    localparam logic [IDX_W-1:0] IDX_C3 = 3'd2;
    localparam logic [IDX_W-1:0] IDX_C4 = 3'd3;
    localparam logic [IDX_W-1:0] IDX_C5 = 3'd4;
    localparam logic [IDX_W-1:0] IDX_C6 = 3'd5;

    typedef struct packed {
        logic advance;
        logic valid;
    } bpc_ctrl_t;

endpackage

>>> design/bpc_pressure.sv
// Final three pipeline stages: split multiplication of D1 by SENS, offset
// subtraction and scaling to pascal. Depends on bpc_pkg.
module bpc_pressure import bpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bpc_ctrl_t                ctrl,
    input  logic [RAW_W-1:0]         d1,
    input  logic signed [SENS_W-1:0] sens,
    input  logic signed [OFF_W-1:0]  off,
    input  logic signed [TEMP_W-1:0] temp,
    output logic                     out_valid,
    output logic signed [TEMP_W-1:0] out_temp,
    output logic signed [P_W-1:0]    out_pressure
);

    logic                     va_reg, vb_reg, vc_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic signed [PHI_W-1:0]  phi_reg;
    logic signed [OFF_W-1:0]  offa_reg;
    logic signed [TEMP_W-1:0] tempa_reg, tempb_reg, tempc_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [P_W-1:0]    p_reg;

    logic [PLO_W-1:0]          plo_next;
    logic signed [PHI_W-1:0]   phi_next;
    logic signed [PROD2_W-1:0] prod;
    logic signed [X_W-1:0]     x_next;
    logic signed [P_W-1:0]     p_next;

    always_comb begin
        plo_next = PLO_W'(d1) * PLO_W'(sens[SLO_W-1:0]);
        phi_next = $signed({1'b0, d1}) * $signed(sens[SENS_W-1:SLO_W]);
        prod = $signed({phi_reg, {SLO_W{1'b0}}})
             + $signed({{(PROD2_W-PLO_W){1'b0}}, plo_reg});
        x_next = $signed({prod[PROD2_W-1], prod[PROD2_W-1:MUL_SHIFT]})
               - $signed({{(X_W-OFF_W){offa_reg[OFF_W-1]}}, offa_reg});
        // The bounds on D1 and SENS keep P well inside 32 bits, so the
        // sign-extended scaled value equals the saturated result.
        p_next = $signed({{(P_W-X_W+P_SHIFT){x_reg[X_W-1]}}, x_reg[X_W-1:P_SHIFT]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (ctrl.advance) begin
            va_reg <= ctrl.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            offa_reg  <= off;
            tempa_reg <= temp;
            x_reg     <= x_next;
            tempb_reg <= tempa_reg;
            p_reg     <= p_next;
            tempc_reg <= tempb_reg;
        end
    end

    assign out_valid    = vc_reg;
    assign out_temp     = tempc_reg;
    assign out_pressure = p_reg;

endmodule

>>> design/baro_pressure_temp_compensation_core.sv
// Barometric pressure and temperature compensation core, eight stages deep.
// Throughput one item per cycle while the output is not stalled, set by the
// fully pipelined multiplier stages.
// The whole pipeline stalls together while a result waits at the output.
// Reset (aresetn, synchronous) empties the pipeline and clears all six
// calibration words to zero.
module baro_pressure_temp_compensation_core import bpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [COEF_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [RAW_W-1:0]         s_raw_temperature,
    input  logic [RAW_W-1:0]         s_raw_pressure,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_comp_temperature,
    output logic signed [P_W-1:0]    m_comp_pressure
);

    logic [COEF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [DT_W-1:0]   dt_reg;
    logic [RAW_W-1:0]         d1a_reg, d1b_reg, d1c_reg, d1d_reg, d1e_reg;
    logic signed [PROD_W-1:0] pc3_reg, pc4_reg, pc6_reg;
    logic signed [OFF_W-1:0]  off1_reg, off1b_reg, off_reg;
    logic signed [SENS_W-1:0] sens1_reg, sens1b_reg, sens_reg;
    logic signed [T1_W-1:0]   t1_reg, t1b_reg;
    logic signed [TC_W-1:0]   tc_reg;
    logic signed [SQ_W-1:0]   sq1_reg, sq2_reg;
    logic                     warm_n_reg, cold_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic signed [DT_W-1:0]   dt_next;
    logic signed [PROD_W-1:0] pc3_next, pc4_next, pc6_next;
    logic signed [OFF_W-1:0]  off1_next, off2, off2_a, off2_b, off_next, sq1e, sq2e;
    logic signed [SENS_W-1:0] sens1_next, sens2, sens2_a, sens2_b, sens_next;
    logic signed [T1_W-1:0]   t1_next;
    logic signed [TC_W-1:0]   tc_next;
    logic signed [SQ_W-1:0]   sq1_next, sq2_next;
    logic signed [TEMP_W-1:0] temp_next;

    bpc_ctrl_t press_ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                IDX_C1:  c1_reg <= cfg_data;
                IDX_C2:  c2_reg <= cfg_data;
                IDX_C3:  c3_reg <= cfg_data;
                IDX_C4:  c4_reg <= cfg_data;
                IDX_C5:  c5_reg <= cfg_data;
                IDX_C6:  c6_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Every stage moves together whenever the output register is empty or being taken.
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    always_comb begin
        dt_next = $signed({1'b0, s_raw_temperature})
                - $signed({1'b0, c5_reg, {C5_SHIFT{1'b0}}});

        pc3_next = dt_reg * $signed({1'b0, c3_reg});
        pc4_next = dt_reg * $signed({1'b0, c4_reg});
        pc6_next = dt_reg * $signed({1'b0, c6_reg});

        // Taking the upper bits of a two's complement product floors it.
        off1_next = $signed({{(OFF_W-COEF_W-C2_SHIFT){1'b0}}, c2_reg, {C2_SHIFT{1'b0}}})
                  + $signed({{(OFF_W-PROD_W+OFF_SHIFT){pc4_reg[PROD_W-1]}},
                             pc4_reg[PROD_W-1:OFF_SHIFT]});
        sens1_next = $signed({{(SENS_W-COEF_W-C1_SHIFT){1'b0}}, c1_reg, {C1_SHIFT{1'b0}}})
                   + $signed({{(SENS_W-PROD_W+SENS_SHIFT){pc3_reg[PROD_W-1]}},
                              pc3_reg[PROD_W-1:SENS_SHIFT]});
        t1_next = pc6_reg[TEMP_SHIFT+T1_W-1:TEMP_SHIFT];
        tc_next = $signed({t1_next[T1_W-1], t1_next}) + COLD_OFS;

        sq1_next = $signed({t1_reg[T1_W-1], t1_reg}) * $signed({t1_reg[T1_W-1], t1_reg});
        sq2_next = tc_reg * tc_reg;

        sq1e = $signed({{(OFF_W-SQ_W){sq1_reg[SQ_W-1]}}, sq1_reg});
        sq2e = $signed({{(OFF_W-SQ_W){sq2_reg[SQ_W-1]}}, sq2_reg});
        off2_a  = (sq1e + (sq1e <<< 2)) >>> 1;
        sens2_a = (sq1e + (sq1e <<< 2)) >>> 2;
        off2_b  = (sq2e <<< 3) - sq2e;
        sens2_b = ((sq2e <<< 3) + (sq2e <<< 1) + sq2e) >>> 1;

        // Second-order terms apply below the reference temperature, and the
        // extra cold terms only below the lower threshold as well.
        off2  = '0;
        sens2 = '0;
        if (warm_n_reg) begin
            off2  = cold_reg ? off2_a + off2_b : off2_a;
            sens2 = cold_reg ? sens2_a + sens2_b : sens2_a;
        end
        off_next  = off1b_reg - off2;
        sens_next = sens1b_reg - sens2;
        temp_next = $signed({t1b_reg[T1_W-1], t1b_reg}) + TEMP_REF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dt_reg     <= dt_next;
            d1a_reg    <= s_raw_pressure;
            pc3_reg    <= pc3_next;
            pc4_reg    <= pc4_next;
            pc6_reg    <= pc6_next;
            d1b_reg    <= d1a_reg;
            off1_reg   <= off1_next;
            sens1_reg  <= sens1_next;
            t1_reg     <= t1_next;
            tc_reg     <= tc_next;
            d1c_reg    <= d1b_reg;
            sq1_reg    <= sq1_next;
            sq2_reg    <= sq2_next;
            warm_n_reg <= t1_reg[T1_W-1];
            cold_reg   <= tc_reg[TC_W-1];
            off1b_reg  <= off1_reg;
            sens1b_reg <= sens1_reg;
            t1b_reg    <= t1_reg;
            d1d_reg    <= d1c_reg;
            off_reg    <= off_next;
            sens_reg   <= sens_next;
            temp_reg   <= temp_next;
            d1e_reg    <= d1d_reg;
        end
    end

    assign press_ctrl.advance = advance;
    assign press_ctrl.valid   = v5_reg;

    bpc_pressure u_pressure (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (press_ctrl),
        .d1           (d1e_reg),
        .sens         (sens_reg),
        .off          (off_reg),
        .temp         (temp_reg),
        .out_valid    (m_valid),
        .out_temp     (m_comp_temperature),
        .out_pressure (m_comp_pressure)
    );

endmodule
